### src/kpm_pkg.sv
// Shared types, constants and fixed CRC tables for the keystream preimage matcher.
// No dependencies; imported by kpm_table, kpm_match and keystream_preimage_matcher.
package kpm_pkg;

  localparam int unsigned ROW_LEN  = 64;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned ROWS     = 256;
  localparam int unsigned KEY_W    = 14;
  localparam int unsigned KEY_SPAN = 16384;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned ADDR_W   = 14;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef logic [KEY_W-1:0] crc_cmp_tab_t [ROWS];
  typedef logic [IDX_W-1:0] crc_inv_tab_t [ROWS];

  // Sequencer view handed to the compare unit
  typedef struct packed {
    logic run;      // an item is in progress
    logic s1_valid; // table read data holds a live preimage
    logic drained;  // all preimages issued and read stage empty
  } kpm_ctl_t;

  // CRC-32 entry of a byte, bit-serial over eight steps
  function automatic logic [31:0] crc_entry(input logic [7:0] b);
    logic [31:0] c;
    c = {24'h0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Bits 15..2 of each CRC table entry
  function automatic crc_cmp_tab_t build_crc_cmp();
    crc_cmp_tab_t t;
    logic [31:0]  c;
    for (int i = 0; i < ROWS; i++) begin
      c    = crc_entry(IDX_W'(i));
      t[i] = c[15:2];
    end
    return t;
  endfunction

  // Inverse table keyed on bits 10..3 of the CRC entry
  function automatic crc_inv_tab_t build_crc_inv();
    crc_inv_tab_t t;
    logic [31:0]  c;
    for (int i = 0; i < ROWS; i++) begin
      t[i] = '0;
    end
    for (int i = 0; i < ROWS; i++) begin
      c         = crc_entry(IDX_W'(i));
      t[c[10:3]] = IDX_W'(i);
    end
    return t;
  endfunction

  localparam crc_cmp_tab_t CRC_CMP = build_crc_cmp();
  localparam crc_inv_tab_t CRC_INV = build_crc_inv();

endpackage

### src/kpm_table.sv
// Preimage table memory (256 rows x 64 keys) and its fill sequencer after reset.
// Depends on kpm_pkg.
module kpm_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [kpm_pkg::ADDR_W-1:0] rd_addr,
  output logic [kpm_pkg::KEY_W-1:0]  rd_key,
  output logic                       fill_done
);
  import kpm_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CNT  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       st_r, st_nxt;
  logic [7:0]       clr_r, clr_nxt;
  logic [KEY_W-1:0] k_r, k_nxt;
  logic [7:0]       s_r;
  logic [ROW_W:0]   cnt_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [15:0]      t_val;
  logic [15:0]      t_prod;

  logic [ROW_W:0]   cnt_mem [ROWS];
  logic [KEY_W-1:0] tbl_mem [ROWS*ROW_LEN];

  // Keystream byte of the current key: bits 15..8 of t*(t^1)
  assign t_val  = {k_r, 2'b11};
  assign t_prod = 16'(t_val * (t_val ^ 16'h0001));

  // Fill sequencer: clear row counts, then step each key through the multiply, count read and write states
  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    k_nxt   = k_r;
    unique case (st_r)
      ST_CLR: begin
        clr_nxt = clr_r + 8'd1;
        if (clr_r == 8'hFF) st_nxt = ST_MUL;
      end
      ST_MUL: st_nxt = ST_CNT;
      ST_CNT: st_nxt = ST_WR;
      ST_WR: begin
        if (k_r == KEY_W'(KEY_SPAN - 1)) begin
          st_nxt = ST_DONE;
        end else begin
          k_nxt  = k_r + KEY_W'(1);
          st_nxt = ST_MUL;
        end
      end
      ST_DONE: st_nxt = ST_DONE;
      default: st_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLR;
      clr_r <= '0;
      k_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      k_r   <= k_nxt;
    end
  end

  // Register the product byte before the count lookup
  always_ff @(posedge clk) begin
    if (st_r == ST_MUL) s_r <= t_prod[15:8];
  end

  // Row count memory: clear, read, bump
  always_ff @(posedge clk) begin
    if (st_r == ST_CLR) begin
      cnt_mem[clr_r] <= '0;
    end else if (st_r == ST_WR) begin
      cnt_mem[s_r] <= cnt_r + (ROW_W+1)'(1);
    end
    if (st_r == ST_CNT) cnt_r <= cnt_mem[s_r];
  end

  // Preimage memory: fill port and registered read port
  always_ff @(posedge clk) begin
    if (st_r == ST_WR && cnt_r < (ROW_W+1)'(ROW_LEN)) begin
      tbl_mem[{s_r, cnt_r[ROW_W-1:0]}] <= k_r;
    end
    if (rd_en) rd_key_r <= tbl_mem[rd_addr];
  end

  assign rd_key    = rd_key_r;
  assign fill_done = (st_r == ST_DONE);

endmodule

### src/kpm_match.sv
// Shared CRC inverse lookup and compare unit, pending match and result register.
// Depends on kpm_pkg.
module kpm_match (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kpm_pkg::kpm_ctl_t         ctl,
  input  logic [kpm_pkg::KEY_W-1:0] rd_key,
  input  logic [kpm_pkg::OFF_W-1:0] offset,
  output logic                      adv,
  output logic                      done,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kpm_pkg::IDX_W-1:0] out_match_index,
  output logic                      out_found,
  output logic                      out_last
);
  import kpm_pkg::*;

  logic             s2_v_r;
  logic [OFF_W-1:0] x_r;
  logic [IDX_W-1:0] idx_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_found_r;
  logic             out_last_r;
  logic [OFF_W-1:0] x_val;
  logic             hit;
  logic             push_mid;
  logic             finish;

  assign x_val    = {(OFF_W-KEY_W)'(0), rd_key} ^ offset;
  assign adv      = !out_valid_r || out_ready;
  assign hit      = s2_v_r && (x_r[OFF_W-1:KEY_W] == '0) && (CRC_CMP[idx_r] == x_r[KEY_W-1:0]);
  assign push_mid = adv && hit && pend_v_r;
  assign finish   = ctl.run && ctl.drained && !s2_v_r && adv;
  assign done     = finish;

  // Inverse lookup stage
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= x_val;
      idx_r <= CRC_INV[x_val[8:1]];
    end
  end

  // Compare stage valid, pending match and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) s2_v_r <= ctl.s1_valid;
      if (finish) begin
        pend_v_r <= 1'b0;
      end else if (adv && hit) begin
        pend_v_r <= 1'b1;
      end
      if (finish || push_mid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the newest match back until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (adv && hit) pend_r <= idx_r;
    if (finish) begin
      out_idx_r   <= pend_v_r ? pend_r : '0;
      out_found_r <= pend_v_r;
      out_last_r  <= 1'b1;
    end else if (push_mid) begin
      out_idx_r   <= pend_r;
      out_found_r <= 1'b1;
      out_last_r  <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

endmodule

### src/keystream_preimage_matcher.sv
// Top level: walks the 64 preimages of an item's row; uses kpm_pkg, kpm_table, kpm_match.
// Output: a match is emitted when the next match of the row turns up, else as the last
// result once the row is walked. One item at a time: in_ready stays low until the item's
// last result is formed. One table read and compare per cycle while the output is free;
// a held out_ready freezes the walk. Reset: in_ready stays low until the table fill ends.
module keystream_preimage_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_offset_value,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_match_index,
  output logic        out_found,
  output logic        out_last
);
  import kpm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              st_r;
  logic [7:0]        row_r;
  logic [OFF_W-1:0]  off_r;
  logic [ROW_W:0]    p_r;
  logic              s1_v_r;
  logic              fill_done;
  logic              adv;
  logic              done;
  logic              issue;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_key;
  kpm_ctl_t          ctl;

  assign in_ready = fill_done && (st_r == ST_IDLE);
  assign issue    = (st_r == ST_RUN) && !p_r[ROW_W];
  assign rd_en    = issue && adv;
  assign rd_addr  = {row_r, p_r[ROW_W-1:0]};

  assign ctl.run      = (st_r == ST_RUN);
  assign ctl.s1_valid = s1_v_r;
  assign ctl.drained  = p_r[ROW_W] && !s1_v_r;

  // Sequencer: issue one preimage read per advancing cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      p_r    <= '0;
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_r   <= ST_RUN;
      p_r    <= '0;
      s1_v_r <= 1'b0;
    end else if (st_r == ST_RUN) begin
      if (adv) begin
        s1_v_r <= issue;
        if (issue) p_r <= p_r + (ROW_W+1)'(1);
      end
      if (done) st_r <= ST_IDLE;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row_r <= in_stream_byte;
      off_r <= in_offset_value;
    end
  end

  kpm_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .fill_done (fill_done)
  );

  kpm_match u_match (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .rd_key          (rd_key),
    .offset          (off_r),
    .adv             (adv),
    .done            (done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_index (out_match_index),
    .out_found       (out_found),
    .out_last        (out_last)
  );

  // A taken item blocks the input until its terminating result is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // A not-found result is always the terminator with index zero
  a_notfound_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && (out_match_index == '0))
    else $error("malformed not-found result");

  // No read stage data left over when a new item may enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !s1_v_r)
    else $error("read stage busy while idle");

  // Sequencer finishes only after every preimage was issued
  a_done_all_issued: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> p_r[ROW_W])
    else $error("item finished before the whole row was walked");

endmodule
